/* design/zcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcs_pkg
// Shared constants and lane control types for the z-score standardizer.
// ----------------------------------------------------------------------------
package zcs_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DATA_W = 16;
  localparam int TOT_W  = 22;   // running sum per channel
  localparam int MEAN_W = 25;   // mean, Q.8
  localparam int DEV_W  = 26;   // deviation, Q.8
  localparam int SQ_W   = 2 * DEV_W;
  localparam int SS_W   = 56;   // sum of squares, Q.16
  localparam int DVD_W  = 64;   // divider dividend / quotient
  localparam int DSR_W  = 32;   // divider divisor
  localparam int STD_W  = 32;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic wr;    // store one sample beat
    logic go;    // set complete, start statistics
    logic req;   // scale the sample at the given index
    logic clr;   // set done, back to loading
  } lane_cmd_t;

  typedef struct packed {
    logic ready;  // statistics done and no scale in flight
    logic zero;   // channel outputs zero (n < 2 or zero deviation)
  } lane_sts_t;

endpackage
`default_nettype wire

/* design/zcs_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zcs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [zcs_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [zcs_pkg::DSR_W-1:0]  divisor_i,
  output logic      [zcs_pkg::DVD_W-1:0]  quotient_o,
  output logic                            done_o
);

  localparam int CW = $clog2(zcs_pkg::DVD_W);

  logic                      run_q, run_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [zcs_pkg::DVD_W-1:0] dvd_q, dvd_d;
  logic [zcs_pkg::DSR_W-1:0] rem_q, rem_d;
  logic [zcs_pkg::DSR_W-1:0] dsr_q, dsr_d;
  logic                      done_q, done_d;
  logic [zcs_pkg::DSR_W:0]   rem_sh;
  logic                      qbit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[zcs_pkg::DVD_W-1]};
    qbit   = (rem_sh >= {1'b0, dsr_q});
    run_d  = run_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (run_q) begin
      rem_d = qbit ? zcs_pkg::DSR_W'(rem_sh - {1'b0, dsr_q})
                   : rem_sh[zcs_pkg::DSR_W-1:0];
      dvd_d = {dvd_q[zcs_pkg::DVD_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(zcs_pkg::DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

/* design/zcs_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zcs_lane
// One channel: sample store, running sum, mean, sample deviation and the
// per-sample scaling, all sequenced around one shared divider.
// ----------------------------------------------------------------------------
module zcs_lane (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire zcs_pkg::lane_cmd_t                 cmd_i,
  input  wire logic        [zcs_pkg::IDX_W-1:0]   wr_addr_i,
  input  wire logic signed [zcs_pkg::DATA_W-1:0]  wr_data_i,
  input  wire logic        [zcs_pkg::CNT_W-1:0]   n_i,
  input  wire logic        [zcs_pkg::IDX_W-1:0]   rd_idx_i,
  output zcs_pkg::lane_sts_t                      sts_o,
  output logic signed      [zcs_pkg::DATA_W-1:0]  scaled_o
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_MEAN_ST = 15'b000000000000010,
    S_MEAN_W  = 15'b000000000000100,
    S_SS_RD   = 15'b000000000001000,
    S_SS_DIFF = 15'b000000000010000,
    S_SS_SQ   = 15'b000000000100000,
    S_SS_ACC  = 15'b000000001000000,
    S_VAR_ST  = 15'b000000010000000,
    S_VAR_W   = 15'b000000100000000,
    S_SQRT    = 15'b000001000000000,
    S_READY   = 15'b000010000000000,
    S_SC_RD   = 15'b000100000000000,
    S_SC_DIFF = 15'b001000000000000,
    S_SC_ST   = 15'b010000000000000,
    S_SC_W    = 15'b100000000000000
  } lane_state_e;

  lane_state_e state_q, state_d;

  logic signed [zcs_pkg::DATA_W-1:0] mem_q [zcs_pkg::MAX_SAMPLES];
  logic signed [zcs_pkg::DATA_W-1:0] rd_q;

  logic signed [zcs_pkg::TOT_W-1:0]  tot_q, tot_d;
  logic        [zcs_pkg::CNT_W-1:0]  n_q, n_d;
  logic        [zcs_pkg::IDX_W-1:0]  ptr_q, ptr_d;
  logic                              zero_q, zero_d;
  logic signed [zcs_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic signed [zcs_pkg::DEV_W-1:0]  dev_q, dev_d;
  logic signed [zcs_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic        [zcs_pkg::SS_W-1:0]   ss_q, ss_d;
  logic        [zcs_pkg::DVD_W-1:0]  sx_q, sx_d, sr_q, sr_d, sb_q, sb_d;
  logic        [zcs_pkg::STD_W-1:0]  std_q, std_d;
  logic signed [zcs_pkg::DATA_W-1:0] res_q, res_d;

  logic        [zcs_pkg::TOT_W-1:0]  tot_mag;
  logic        [zcs_pkg::DEV_W-1:0]  dev_mag;
  logic        [zcs_pkg::DVD_W-1:0]  sq_t, sr_new;
  logic        [zcs_pkg::MEAN_W-1:0] mean_mag;
  logic                              div_start, div_done;
  logic        [zcs_pkg::DVD_W-1:0]  div_dvd, div_quo;
  logic        [zcs_pkg::DSR_W-1:0]  div_dsr;

  zcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[ptr_q];
  end

  always_comb begin
    tot_mag  = tot_q[zcs_pkg::TOT_W-1] ? zcs_pkg::TOT_W'(-tot_q) : tot_q;
    dev_mag  = dev_q[zcs_pkg::DEV_W-1] ? zcs_pkg::DEV_W'(-dev_q) : dev_q;
    mean_mag = div_quo[zcs_pkg::MEAN_W-1:0];
    sq_t     = sr_q + sb_q;
    sr_new   = (sx_q >= sq_t) ? (sr_q >> 1) + sb_q : (sr_q >> 1);
    div_start = (state_q == S_MEAN_ST) || (state_q == S_VAR_ST) || (state_q == S_SC_ST);
    unique case (state_q)
      S_MEAN_ST: begin
        div_dvd = {34'd0, tot_mag, 8'd0};
        div_dsr = {25'd0, n_q};
      end
      S_VAR_ST: begin
        div_dvd = {ss_q, 8'd0};
        div_dsr = {25'd0, n_q - 7'd1};
      end
      default: begin
        div_dvd = {23'd0, dev_mag[zcs_pkg::DEV_W-2:0], 16'd0};
        div_dsr = std_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    tot_d   = tot_q;
    n_d     = n_q;
    ptr_d   = ptr_q;
    zero_d  = zero_q;
    mean_d  = mean_q;
    dev_d   = {{2{rd_q[zcs_pkg::DATA_W-1]}}, rd_q, 8'd0} - {mean_q[zcs_pkg::MEAN_W-1], mean_q};
    sq_d    = dev_q * dev_q;
    ss_d    = ss_q;
    sx_d    = sx_q;
    sr_d    = sr_q;
    sb_d    = sb_q;
    std_d   = std_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.wr) begin
          tot_d = tot_q + zcs_pkg::TOT_W'(wr_data_i);
        end
        if (cmd_i.go) begin
          n_d   = n_i;
          ptr_d = '0;
          ss_d  = '0;
          res_d = '0;
          if (n_i < 7'd2) begin
            zero_d  = 1'b1;
            state_d = S_READY;
          end else begin
            zero_d  = 1'b0;
            state_d = S_MEAN_ST;
          end
        end
      end
      S_MEAN_ST: state_d = S_MEAN_W;
      S_MEAN_W: begin
        if (div_done) begin
          mean_d  = tot_q[zcs_pkg::TOT_W-1] ? zcs_pkg::MEAN_W'(-mean_mag) : mean_mag;
          state_d = S_SS_RD;
        end
      end
      S_SS_RD:   state_d = S_SS_DIFF;
      S_SS_DIFF: state_d = S_SS_SQ;
      S_SS_SQ:   state_d = S_SS_ACC;
      S_SS_ACC: begin
        ss_d = ss_q + {4'd0, sq_q};
        if ({1'b0, ptr_q} == n_q - 7'd1) begin
          state_d = S_VAR_ST;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_SS_RD;
        end
      end
      S_VAR_ST: state_d = S_VAR_W;
      S_VAR_W: begin
        if (div_done) begin
          sx_d    = div_quo;
          sr_d    = '0;
          sb_d    = 64'd1 << 62;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // bitwise integer square root, two radicand bits per step
        if (sx_q >= sq_t) begin
          sx_d = sx_q - sq_t;
        end
        sr_d = sr_new;
        sb_d = sb_q >> 2;
        if (sb_q[0]) begin
          std_d   = sr_new[zcs_pkg::STD_W-1:0];
          zero_d  = (sr_new == '0);
          state_d = S_READY;
        end
      end
      S_READY: begin
        if (cmd_i.clr) begin
          tot_d   = '0;
          state_d = S_IDLE;
        end else if (cmd_i.req && !zero_q) begin
          ptr_d   = rd_idx_i;
          state_d = S_SC_RD;
        end
      end
      S_SC_RD:   state_d = S_SC_DIFF;
      S_SC_DIFF: state_d = S_SC_ST;
      S_SC_ST:   state_d = S_SC_W;
      S_SC_W: begin
        if (div_done) begin
          if (dev_q[zcs_pkg::DEV_W-1]) begin
            res_d = (div_quo > 64'd32768) ? zcs_pkg::SAT_MIN
                                          : zcs_pkg::DATA_W'(-div_quo[zcs_pkg::DATA_W-1:0]);
          end else begin
            res_d = (div_quo > 64'd32767) ? zcs_pkg::SAT_MAX
                                          : div_quo[zcs_pkg::DATA_W-1:0];
          end
          state_d = S_READY;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tot_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tot_q   <= tot_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    ptr_q  <= ptr_d;
    mean_q <= mean_d;
    dev_q  <= dev_d;
    sq_q   <= sq_d;
    ss_q   <= ss_d;
    sx_q   <= sx_d;
    sr_q   <= sr_d;
    sb_q   <= sb_d;
    std_q  <= std_d;
    res_q  <= res_d;
  end

  assign sts_o.ready = (state_q == S_READY);
  assign sts_o.zero  = zero_q;
  assign scaled_o    = zero_q ? '0 : res_q;

endmodule
`default_nettype wire

/* design/two_channel_zscore_standardizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_channel_zscore_standardizer
// Collects (x, y) samples, then emits each one standardized per channel
// (sample deviation, Q4.12, saturated).
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | start && !busy            | x_sample_i, y_sample_i, last_sample_i
//  result   | result_valid_o (1 cycle)  | x_scaled_o, y_scaled_o, last_result_o,
//           |                           | degenerate_flag_o, dropped_flag_o
//
//  Loading takes one sample beat per cycle; busy stays low until the beat
//  marked last.
//  After it, each lane runs its statistics: one divide for the mean, a
//  read, difference, square and accumulate step per stored sample for the
//  sum of squares, one divide for the variance and 32 root steps.
//  Each result then needs one divide per lane; the next is requested only after both lanes are done.
//  Reset clears the count, totals and state; stores are not cleared.
//  The receiver cannot stall: each result beat is shown for one cycle.
// ----------------------------------------------------------------------------
module two_channel_zscore_standardizer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [zcs_pkg::DATA_W-1:0]  x_sample_i,
  input  wire logic signed [zcs_pkg::DATA_W-1:0]  y_sample_i,
  input  wire logic                               last_sample_i,
  output logic                                    result_valid_o,
  output logic signed      [zcs_pkg::DATA_W-1:0]  x_scaled_o,
  output logic signed      [zcs_pkg::DATA_W-1:0]  y_scaled_o,
  output logic                                    last_result_o,
  output logic                                    degenerate_flag_o,
  output logic                                    dropped_flag_o
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_STATS = 4'b0010,
    S_REQ   = 4'b0100,
    S_WAIT  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [zcs_pkg::CNT_W-1:0] cnt_q, cnt_d, n_q, n_d, n_new;
  logic [zcs_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                      ovf_q, ovf_d;
  logic                      accept, full, both_ready, is_last;

  zcs_pkg::lane_cmd_t        cmd;
  zcs_pkg::lane_sts_t        x_sts, y_sts;
  logic signed [zcs_pkg::DATA_W-1:0] x_val, y_val;

  logic                              vld_q, vld_d, lst_q, lst_d, dgn_q, dgn_d, drp_q, drp_d;
  logic signed [zcs_pkg::DATA_W-1:0] xo_q, xo_d, yo_q, yo_d;

  assign busy       = (state_q != S_LOAD);
  assign accept     = start && !busy;
  assign full       = (cnt_q == zcs_pkg::CNT_W'(zcs_pkg::MAX_SAMPLES));
  assign n_new      = full ? cnt_q : cnt_q + 1'b1;
  assign both_ready = x_sts.ready && y_sts.ready;
  assign is_last    = ({1'b0, idx_q} + 1'b1) == n_q;

  // lane commands
  assign cmd.wr  = accept && !full;
  assign cmd.go  = accept && last_sample_i;
  assign cmd.req = (state_q == S_REQ);
  assign cmd.clr = (state_q == S_WAIT) && both_ready && is_last;

  zcs_lane u_lane_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (cnt_q[zcs_pkg::IDX_W-1:0]),
    .wr_data_i (x_sample_i),
    .n_i       (n_new),
    .rd_idx_i  (idx_q),
    .sts_o     (x_sts),
    .scaled_o  (x_val)
  );

  zcs_lane u_lane_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (cnt_q[zcs_pkg::IDX_W-1:0]),
    .wr_data_i (y_sample_i),
    .n_i       (n_new),
    .rd_idx_i  (idx_q),
    .sts_o     (y_sts),
    .scaled_o  (y_val)
  );

  // sequencer and merge of the two lane results
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    vld_d   = 1'b0;
    lst_d   = lst_q;
    dgn_d   = dgn_q;
    drp_d   = drp_q;
    xo_d    = xo_q;
    yo_d    = yo_q;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
          if (last_sample_i) begin
            n_d     = n_new;
            idx_d   = '0;
            state_d = S_STATS;
          end
        end
      end
      S_STATS: begin
        if (both_ready) begin
          state_d = S_REQ;
        end
      end
      S_REQ: state_d = S_WAIT;
      S_WAIT: begin
        if (both_ready) begin
          vld_d = 1'b1;
          xo_d  = x_val;
          yo_d  = y_val;
          lst_d = is_last;
          dgn_d = x_sts.zero || y_sts.zero;
          drp_d = ovf_q;
          if (is_last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_REQ;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    idx_q <= idx_d;
    lst_q <= lst_d;
    dgn_q <= dgn_d;
    drp_q <= drp_d;
    xo_q  <= xo_d;
    yo_q  <= yo_d;
  end

  assign result_valid_o    = vld_q;
  assign x_scaled_o        = xo_q;
  assign y_scaled_o        = yo_q;
  assign last_result_o     = lst_q;
  assign degenerate_flag_o = dgn_q;
  assign dropped_flag_o    = drp_q;

  // store fill never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= zcs_pkg::CNT_W'(zcs_pkg::MAX_SAMPLES))
    else $error("sample count beyond capacity");

  // result beats never come back to back
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beats back to back");

  // final result of a set reopens loading
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |-> !busy)
    else $error("still busy after last result");

  // a last sample beat closes loading
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_sample_i) |=> busy)
    else $error("loading not closed by last sample");

endmodule
`default_nettype wire

/* tb/two_channel_zscore_standardizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_zscore_standardizer_tb
// Feeds sample sets (directed corner sets, then random sets of mixed size and
// spread) and checks every standardized result beat against a built-in
// mean / sample-deviation predictor, in order, field by field.
// ----------------------------------------------------------------------------
module two_channel_zscore_standardizer_tb;

  typedef struct {
    logic signed [zcs_pkg::DATA_W-1:0] xv;
    logic signed [zcs_pkg::DATA_W-1:0] yv;
    logic                              last;
    int                                gap;    // idle cycles after this beat
    bit                                drain;  // hold until all results are back
  } sample_t;

  typedef struct {
    logic signed [zcs_pkg::DATA_W-1:0] xs;
    logic signed [zcs_pkg::DATA_W-1:0] ys;
    logic                              last;
    logic                              degen;
    logic                              dropped;
  } zresult_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [zcs_pkg::DATA_W-1:0] x_sample_i = '0;
  logic signed [zcs_pkg::DATA_W-1:0] y_sample_i = '0;
  logic last_sample_i = 1'b0;
  logic result_valid_o;
  logic signed [zcs_pkg::DATA_W-1:0] x_scaled_o, y_scaled_o;
  logic last_result_o, degenerate_flag_o, dropped_flag_o;

  two_channel_zscore_standardizer u_dut (
    .clk_i, .rst_ni, .start, .busy, .x_sample_i, .y_sample_i, .last_sample_i,
    .result_valid_o, .x_scaled_o, .y_scaled_o, .last_result_o,
    .degenerate_flag_o, .dropped_flag_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: mirror of the sample stores and running sums.
  logic signed [zcs_pkg::DATA_W-1:0] x_mem [zcs_pkg::MAX_SAMPLES];
  logic signed [zcs_pkg::DATA_W-1:0] y_mem [zcs_pkg::MAX_SAMPLES];
  int     n_held;
  longint x_sum, y_sum;
  bit     over_flag;

  sample_t  pend_q [$];
  zresult_t zscore_q [$];
  int mism_cnt, res_cnt, set_cnt, degen_cnt, drop_cnt;
  bit taken;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q.8 mean and Q.12 deviation of one channel over the held samples.
  function automatic void chan_stats(bit is_y, output longint mean_q8,
                                     output longint std_q12);
    longint d, tot;
    longint unsigned ss;
    ss = 0;
    tot = is_y ? y_sum : x_sum;
    mean_q8 = (tot * 256) / n_held;
    for (int i = 0; i < n_held; i++) begin
      d = longint'(is_y ? y_mem[i] : x_mem[i]) * 256 - mean_q8;
      ss += longint'(d * d);
    end
    std_q12 = longint'(int_sqrt((ss * 256) / longint'(n_held - 1)));
  endfunction

  function automatic logic signed [zcs_pkg::DATA_W-1:0] zscale(
      logic signed [zcs_pkg::DATA_W-1:0] v, longint mean_q8, longint std_q12);
    longint q;
    q = ((longint'(v) * 256 - mean_q8) * 65536) / std_q12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[zcs_pkg::DATA_W-1:0];
  endfunction

  task automatic predict_beat(logic signed [zcs_pkg::DATA_W-1:0] xv,
                              logic signed [zcs_pkg::DATA_W-1:0] yv, logic last);
    longint xm, ym, xd, yd;
    zresult_t r;
    bit degen;
    if (n_held < zcs_pkg::MAX_SAMPLES) begin
      x_mem[n_held] = xv;
      y_mem[n_held] = yv;
      x_sum += xv;
      y_sum += yv;
      n_held++;
    end else begin
      over_flag = 1'b1;
    end
    if (!last) return;
    xd = 0;
    yd = 0;
    degen = 1'b1;
    if (n_held >= 2) begin
      chan_stats(1'b0, xm, xd);
      chan_stats(1'b1, ym, yd);
      degen = (xd == 0) || (yd == 0);
    end
    set_cnt++;
    if (degen) degen_cnt++;
    if (over_flag) drop_cnt++;
    for (int i = 0; i < n_held; i++) begin
      r.xs = (xd != 0) ? zscale(x_mem[i], xm, xd) : '0;
      r.ys = (yd != 0) ? zscale(y_mem[i], ym, yd) : '0;
      r.last = (i == n_held - 1);
      r.degen = degen;
      r.dropped = over_flag;
      zscore_q = {zscore_q, r};
    end
    n_held = 0;
    x_sum = 0;
    y_sum = 0;
    over_flag = 1'b0;
  endtask

  // Monitor: predict on each accepted sample beat, check each result beat.
  always @(posedge clk_i) begin
    zresult_t e;
    taken <= start && !busy;
    if (rst_ni && start && !busy) predict_beat(x_sample_i, y_sample_i, last_sample_i);
    if (rst_ni && result_valid_o) begin
      res_cnt++;
      if (zscore_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("ERROR: unexpected result beat at %0t", $time);
      end else begin
        e = zscore_q.pop_front();
        if (x_scaled_o !== e.xs || y_scaled_o !== e.ys || last_result_o !== e.last ||
            degenerate_flag_o !== e.degen || dropped_flag_o !== e.dropped) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display({"ERROR: result %0d exp x=%0d y=%0d l=%b dg=%b dr=%b ",
                      "got x=%0d y=%0d l=%b dg=%b dr=%b"},
                     res_cnt, e.xs, e.ys, e.last, e.degen, e.dropped, x_scaled_o,
                     y_scaled_o, last_result_o, degenerate_flag_o, dropped_flag_o);
        end
      end
    end
  end

  // Driver: one beat at a time from the pending queue, with random gaps.
  int gap_left;
  always @(negedge clk_i) begin
    sample_t s;
    if (rst_ni && (!start || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pend_q.size() > 0 && !(pend_q[0].drain && zscore_q.size() > 0)) begin
        s = pend_q.pop_front();
        x_sample_i <= s.xv;
        y_sample_i <= s.yv;
        last_sample_i <= s.last;
        gap_left = s.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Queue one set. spread 0 gives constant values, 65535 or more fully random
  // values, otherwise values base +/- spread; gaps off for the burst sets.
  task automatic queue_set(int n, int spread, bit gaps, bit drain_first);
    sample_t s;
    int bx, by;
    bx = $urandom_range(65535) - 32768;
    by = $urandom_range(65535) - 32768;
    for (int i = 0; i < n; i++) begin
      if (spread >= 65535) begin
        s.xv = zcs_pkg::DATA_W'($urandom);
        s.yv = zcs_pkg::DATA_W'($urandom);
      end else begin
        s.xv = zcs_pkg::DATA_W'(bx + $urandom_range(2 * spread) - spread);
        s.yv = zcs_pkg::DATA_W'(by + $urandom_range(2 * spread) - spread);
      end
      s.last = (i == n - 1);
      s.gap = gaps ? $urandom_range(4) : 0;
      s.drain = drain_first && (i == 0);
      pend_q = {pend_q, s};
    end
  endtask

  task automatic queue_fixed(logic signed [zcs_pkg::DATA_W-1:0] xv,
                             logic signed [zcs_pkg::DATA_W-1:0] yv, logic last);
    sample_t s;
    s.xv = xv;
    s.yv = yv;
    s.last = last;
    s.gap = $urandom_range(4);
    s.drain = 1'b0;
    pend_q = {pend_q, s};
  endtask

  initial begin
    int items, n;
    n_held = 0;
    x_sum = 0;
    y_sum = 0;
    over_flag = 0;
    gap_left = 0;

    // Directed: single-sample set, both channels constant, one channel
    // constant, full-scale extremes, then a two-sample set.
    queue_fixed(16'sh7FFF, 16'sh8000, 1'b1);
    queue_fixed(16'sd5, -16'sd5, 1'b0);
    queue_fixed(16'sd5, -16'sd5, 1'b1);
    queue_fixed(16'sd100, 16'sd1, 1'b0);
    queue_fixed(16'sd100, 16'sd2, 1'b0);
    queue_fixed(16'sd100, 16'sd3, 1'b1);
    for (int i = 0; i < 8; i++)
      queue_fixed(i[0] ? 16'sh7FFF : 16'sh8000, i[1] ? 16'sh8000 : 16'sh7FFF, i == 7);
    queue_fixed(16'sh8000, 16'sh0000, 1'b0);
    queue_fixed(16'sh7FFF, 16'shFFFF, 1'b1);
    items = pend_q.size();

    // Random: store overflow once (also drains first), then mixed sets.
    queue_set(67, 65535, 1'b1, 1'b1);
    items += 67;
    while (items < 300) begin
      case ($urandom_range(9))
        0:       n = 1;
        1:       n = $urandom_range(20, 64);
        2:       n = $urandom_range(65, 68);
        default: n = $urandom_range(2, 10);
      endcase
      queue_set(n, ($urandom_range(3) == 0) ? $urandom_range(40) : 65535,
                $urandom_range(3) != 0, $urandom_range(7) == 0);
      items += n;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (pend_q.size() == 0 && !start);
    wait (zscore_q.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("Checked %0d result beats over %0d sets (%0d degenerate, %0d with drops).",
             res_cnt, set_cnt, degen_cnt, drop_cnt);
    if (mism_cnt == 0 && zscore_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("Mismatches: %0d", mism_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50ms;
    $display("Timeout: %0d results still expected", zscore_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
